[hdl/rmr_pkg.sv]
// Package with the shared constants, types and tables of the regret matching row unit.
package rmr_pkg;

  localparam int ROW_SLOTS   = 16;
  localparam int IDX_W       = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ROW_SLOTS + 1);
  localparam int NUM_BANKS   = 2;
  localparam int BANK_W      = 1;
  localparam int ADDR_W      = BANK_W + IDX_W;
  localparam int DEPTH       = NUM_BANKS * ROW_SLOTS;

  localparam int REGRET_W = 48;
  localparam int SUM_W    = 47;
  localparam int TOTAL_W  = 51;
  localparam int PROB_W   = 17;
  localparam int AIDX_W   = 4;
  localparam int REM_W    = TOTAL_W + 1;
  localparam int DIV_STEPS = PROB_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [PROB_W-1:0]  ONE_Q16   = PROB_W'(65536);
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Uniform strategy 1/n in Q1.16, indexed by the row length n.
  localparam logic [PROB_W-1:0] RECIP_TABLE [0:ROW_SLOTS] = '{
    17'd0,     17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107,
    17'd10922, 17'd9362,  17'd8192,  17'd7281,  17'd6553,  17'd5957,
    17'd5461,  17'd5041,  17'd4681,  17'd4369,  17'd4096
  };

  typedef struct packed {
    logic [SUM_W-1:0] pos;
    logic [SUM_W-1:0] old;
  } rmr_entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    rmr_entry_t        data;
  } rmr_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic [TOTAL_W-1:0] total;
    logic [PROB_W-1:0]  weight;
  } rmr_job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [BANK_W-1:0] wr_ptr;
    logic [BANK_W-1:0] rd_ptr;
  } rmr_qstat_t;

  function automatic logic [PROB_W-1:0] clamp_q16(input logic [PROB_W-1:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

endpackage

[hdl/regret_matching_row_unit_top.sv]
// Top level of the regret matching row unit: front end, row queue, back end, discount register.
//
//   Channel | Direction | Handshake              | Payload
//   in_     | input     | in_valid / in_stall    | regret, old sum, weight, last flag
//   out_    | output    | out_valid / out_stall  | index, strategy, new sum, last flag
//   cfg_    | input     | cfg_wr_en              | strategy_discount (17 bits)
//
// The front end takes one action per cycle while in_stall is low and writes it into one
// of two buffer banks. A row ends on last_action or when ROW_SLOTS actions have arrived;
// it then queues as a job. Each result passes through the back end in turn: a memory
// read, a load, the one-bit-per-cycle restoring divider (skipped when the row's regret
// total is zero), a multiply and a saturating add. in_stall rises only while both banks
// hold rows not yet drained. Reset is synchronous, active low, and clears all control
// state; the buffer banks need no clearing.
module regret_matching_row_unit_top import rmr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [REGRET_W-1:0] in_regret,
  input  logic [SUM_W-1:0]           in_old_strategy_sum,
  input  logic [PROB_W-1:0]          in_realization_weight,
  input  logic                       in_last_action,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [AIDX_W-1:0]          out_action_index,
  output logic [PROB_W-1:0]          out_strategy,
  output logic [SUM_W-1:0]           out_new_strategy_sum,
  output logic                       out_last_result,
  input  logic                       cfg_wr_en,
  input  logic [PROB_W-1:0]          cfg_wr_data
);

  // The discount register keeps the raw value; values above one act as one.
  logic [PROB_W-1:0] disc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_r <= ONE_Q16;
    end else if (cfg_wr_en) begin
      disc_r <= cfg_wr_data;
    end
  end

  rmr_qstat_t qstat;
  rmr_job_t   push_job, head_job;
  rmr_wr_t    wr;
  logic       push, pop;

  // The front end classifies each transaction and closes rows.
  rmr_front u_front (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_regret            (in_regret),
    .in_old_strategy_sum  (in_old_strategy_sum),
    .in_realization_weight(in_realization_weight),
    .in_last_action       (in_last_action),
    .qstat                (qstat),
    .push                 (push),
    .push_job             (push_job),
    .wr                   (wr)
  );

  // Each queued job owns one buffer bank until its last result is handed over.
  rmr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .stat    (qstat)
  );

  // The back end drains the oldest row, one result transaction per action.
  rmr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .wr                  (wr),
    .qstat               (qstat),
    .job                 (head_job),
    .disc                (clamp_q16(disc_r)),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action_index    (out_action_index),
    .out_strategy        (out_strategy),
    .out_new_strategy_sum(out_new_strategy_sum),
    .out_last_result     (out_last_result)
  );

endmodule

[hdl/rmr_queue.sv]
// Two-entry queue of finished rows; each entry owns one buffer bank until popped.
module rmr_queue import rmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  rmr_job_t   push_job,
  input  logic       pop,
  output rmr_job_t   head_job,
  output rmr_qstat_t stat
);

  rmr_job_t          jobs_r [0:NUM_BANKS-1];
  logic [BANK_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [BANK_W:0]   cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) jobs_r[wr_ptr_r] <= push_job;
  end

  assign head_job    = jobs_r[rd_ptr_r];
  assign stat.full   = (cnt_r == (BANK_W+1)'(NUM_BANKS));
  assign stat.empty  = (cnt_r == '0);
  assign stat.wr_ptr = wr_ptr_r;
  assign stat.rd_ptr = rd_ptr_r;

endmodule

[hdl/rmr_front.sv]
// Front end: accepts actions, buffers them into a bank and closes rows into jobs.
module rmr_front import rmr_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [REGRET_W-1:0] in_regret,
  input  logic [SUM_W-1:0]           in_old_strategy_sum,
  input  logic [PROB_W-1:0]          in_realization_weight,
  input  logic                       in_last_action,
  input  rmr_qstat_t                 qstat,
  output logic                       push,
  output rmr_job_t                   push_job,
  output rmr_wr_t                    wr
);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [PROB_W-1:0]  weight_r, weight_nxt;
  logic               accept, first, row_end;
  logic [IDX_W-1:0]   idx;
  logic [SUM_W-1:0]   pos;
  logic [TOTAL_W:0]   sum;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign idx      = cnt_r[IDX_W-1:0];
  assign first    = (cnt_r == '0);
  assign pos      = in_regret[REGRET_W-1] ? '0 : in_regret[SUM_W-1:0];
  assign sum      = {1'b0, (first ? '0 : total_r)} + (TOTAL_W+1)'(pos);
  assign cnt_nxt  = cnt_r + 1'b1;
  assign row_end  = in_last_action || (cnt_nxt == CNT_W'(ROW_SLOTS));

  always_comb begin
    total_nxt  = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    weight_nxt = first ? in_realization_weight : weight_r;
  end

  assign wr.en         = accept;
  assign wr.addr       = {qstat.wr_ptr, idx};
  assign wr.data.pos   = pos;
  assign wr.data.old   = in_old_strategy_sum;
  assign push          = accept && row_end;
  assign push_job.n      = cnt_nxt;
  assign push_job.total  = total_nxt;
  assign push_job.weight = clamp_q16(weight_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      total_r  <= '0;
      weight_r <= '0;
    end else if (accept) begin
      cnt_r    <= row_end ? '0 : cnt_nxt;
      total_r  <= total_nxt;
      weight_r <= weight_nxt;
    end
  end

endmodule

[hdl/rmr_back.sv]
// Back end: per buffered action, divides (skipped for a zero regret total), multiplies, saturates and emits one result.
module rmr_back import rmr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  rmr_wr_t            wr,
  input  rmr_qstat_t         qstat,
  input  rmr_job_t           job,
  input  logic [PROB_W-1:0]  disc,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [AIDX_W-1:0]  out_action_index,
  output logic [PROB_W-1:0]  out_strategy,
  output logic [SUM_W-1:0]   out_new_strategy_sum,
  output logic               out_last_result
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_LOAD = 6'b000100,
    S_DIV  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  rmr_entry_t mem [0:DEPTH-1];
  rmr_entry_t rd_r;

  logic [CNT_W-1:0]   k_r;
  logic [STEP_W-1:0]  step_r;
  logic [REM_W-1:0]   rem_r;
  logic [PROB_W-1:0]  q_r;
  logic [SUM_W-1:0]   old_r;
  logic [63:0]        prod_old_r;
  logic [33:0]        prod_w_r;
  logic [SUM_W-1:0]   ns_r;
  logic               ns_ready_r;
  logic               out_valid_r;
  logic [AIDX_W-1:0]  out_idx_r;
  logic [PROB_W-1:0]  out_s_r;
  logic [SUM_W-1:0]   out_ns_r;
  logic               out_last_r;

  logic               ge, last_step, is_last, out_free;
  logic [REM_W-1:0]   rem_sub;
  logic [64:0]        acc;
  logic [48:0]        acc_hi;

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr.addr] <= wr.data;
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[{qstat.rd_ptr, k_r[IDX_W-1:0]}];
  end

  assign ge        = (rem_r >= REM_W'(job.total));
  assign rem_sub   = ge ? rem_r - REM_W'(job.total) : rem_r;
  assign last_step = (step_r == STEP_W'(DIV_STEPS - 1));
  assign is_last   = ((k_r + 1'b1) == job.n);
  assign out_free  = !out_valid_r || !out_stall;
  assign acc       = 65'(prod_old_r) + 65'(prod_w_r);
  assign acc_hi    = acc[64:16];
  assign pop       = (state_r == S_OUT) && ns_ready_r && out_free && is_last;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!qstat.empty) state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = (job.total == '0) ? S_MUL : S_DIV;
      S_DIV:  if (last_step) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (ns_ready_r && out_free) state_nxt = is_last ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      step_r      <= '0;
      ns_ready_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_OUT) && ns_ready_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: step_r <= '0;
        S_DIV:  step_r <= step_r + 1'b1;
        S_MUL:  ns_ready_r <= 1'b0;
        S_OUT: begin
          if (!ns_ready_r) begin
            ns_ready_r <= 1'b1;
          end else if (out_free) begin
            ns_ready_r  <= 1'b0;
            k_r         <= is_last ? '0 : k_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_LOAD: begin
        rem_r <= REM_W'(rd_r.pos);
        old_r <= rd_r.old;
        q_r   <= RECIP_TABLE[job.n];
      end
      S_DIV: begin
        q_r   <= {q_r[PROB_W-2:0], ge};
        rem_r <= last_step ? rem_sub : {rem_sub[REM_W-2:0], 1'b0};
      end
      S_MUL: begin
        prod_old_r <= 64'(old_r) * 64'(disc);
        prod_w_r   <= 34'(job.weight) * 34'(clamp_q16(q_r));
      end
      S_OUT: begin
        if (!ns_ready_r) begin
          ns_r <= (acc_hi > 49'(SUM_MAX)) ? SUM_MAX : acc_hi[SUM_W-1:0];
        end else if (out_free) begin
          out_idx_r  <= AIDX_W'(k_r);
          out_s_r    <= clamp_q16(q_r);
          out_ns_r   <= ns_r;
          out_last_r <= is_last;
        end
      end
      default: ;
    endcase
  end

  assign out_valid            = out_valid_r;
  assign out_action_index     = out_idx_r;
  assign out_strategy         = out_s_r;
  assign out_new_strategy_sum = out_ns_r;
  assign out_last_result      = out_last_r;

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty) else $error("row retired from an empty queue");

  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_s_r <= ONE_Q16)) else $error("strategy above one");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r < STEP_W'(DIV_STEPS)))
    else $error("divider ran past its step count");

  a_job_present: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !qstat.empty) else $error("back end busy without a row");

endmodule

[sim/regret_matching_row_unit_top_tb.sv]
// Self-checking testbench for the regret matching row unit: directed rows, then random rows.
`timescale 1ns / 1ps

module regret_matching_row_unit_top_tb;
  import rmr_pkg::*;

  typedef struct {
    logic [AIDX_W-1:0] idx;
    logic [PROB_W-1:0] strategy;
    logic [SUM_W-1:0]  new_sum;
    logic              last;
  } row_result_t;

  // The scoreboard keeps its own copy of the row buffer and the discount register.
  // Every accepted transaction on the input side is folded into that copy, and a
  // completed row pushes one expected result per buffered action.
  class row_scoreboard;
    bit [63:0]   discount;
    bit [63:0]   pos_buf [ROW_SLOTS];
    bit [63:0]   old_buf [ROW_SLOTS];
    bit [63:0]   weight;
    bit [63:0]   total;
    int          count;
    int          errors;
    row_result_t expected_q [$];

    function new();
      discount = 64'd65536;
      weight = 0;
      total = 0;
      count = 0;
      errors = 0;
    endfunction

    function void note_action(logic [REGRET_W-1:0] r, logic [SUM_W-1:0] old,
                              logic [PROB_W-1:0] w, logic last);
      bit [63:0]   pos;
      bit [63:0]   s;
      bit [63:0]   acc;
      bit [63:0]   d;
      bit [63:0]   wt;
      row_result_t res;
      if (count >= ROW_SLOTS) count = 0;
      if (count == 0) begin
        weight = 64'(w);
        total = 0;
      end
      pos = r[REGRET_W-1] ? 64'd0 : {17'd0, r[SUM_W-1:0]};
      pos_buf[count] = pos;
      old_buf[count] = 64'(old);
      total += pos;
      if (total > TOTAL_MAX) total = 64'(TOTAL_MAX);
      count++;
      if (!last && count < ROW_SLOTS) return;
      // The row is complete: both the discount and the weight clamp at one.
      d = (discount > 64'd65536) ? 64'd65536 : discount;
      wt = (weight > 64'd65536) ? 64'd65536 : weight;
      for (int k = 0; k < count; k++) begin
        if (total != 0) s = (pos_buf[k] << 16) / total;
        else s = 64'd65536 / count;
        if (s > 64'd65536) s = 64'd65536;
        acc = (old_buf[k] * d + wt * s) >> 16;
        if (acc > SUM_MAX) acc = 64'(SUM_MAX);
        res.idx = k[AIDX_W-1:0];
        res.strategy = s[PROB_W-1:0];
        res.new_sum = acc[SUM_W-1:0];
        res.last = (k + 1 == count);
        expected_q.push_back(res);
      end
      count = 0;
      total = 0;
      weight = 0;
    endfunction

    function void check_result(row_result_t got);
      row_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("Unexpected result transaction: action_index %0d", got.idx);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.idx !== exp_r.idx) begin
        $error("action_index: expected %0d, got %0d", exp_r.idx, got.idx);
        errors++;
      end
      if (got.strategy !== exp_r.strategy) begin
        $error("strategy: expected %0d, got %0d", exp_r.strategy, got.strategy);
        errors++;
      end
      if (got.new_sum !== exp_r.new_sum) begin
        $error("new_strategy_sum: expected %0d, got %0d", exp_r.new_sum, got.new_sum);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last_result: expected %0d, got %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 2000000;
  // Settling time that drain_rows adds after the last expected result has come back.
  localparam int DRAIN_CYCLES = 400;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [REGRET_W-1:0] in_regret;
  logic [SUM_W-1:0]           in_old_strategy_sum;
  logic [PROB_W-1:0]          in_realization_weight;
  logic                       in_last_action;
  logic                       out_valid;
  logic                       out_stall;
  logic [AIDX_W-1:0]          out_action_index;
  logic [PROB_W-1:0]          out_strategy;
  logic [SUM_W-1:0]           out_new_strategy_sum;
  logic                       out_last_result;
  logic                       cfg_wr_en;
  logic [PROB_W-1:0]          cfg_wr_data;

  row_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            hold_cycles;
  int            actions_sent;
  int            cycle_count;

  regret_matching_row_unit_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_regret            (in_regret),
    .in_old_strategy_sum  (in_old_strategy_sum),
    .in_realization_weight(in_realization_weight),
    .in_last_action       (in_last_action),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_action_index     (out_action_index),
    .out_strategy         (out_strategy),
    .out_new_strategy_sum (out_new_strategy_sum),
    .out_last_result      (out_last_result),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check every accepted result transaction, then pick the next stall.
  // A pending hold-off keeps the receiver stalled for a long stretch so that both
  // buffer banks fill and the block pushes back on its input.
  always @(posedge clk) begin
    row_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.idx = out_action_index;
      got.strategy = out_strategy;
      got.new_sum = out_new_strategy_sum;
      got.last = out_last_result;
      sb.check_result(got);
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offers one action and returns at the edge where it is accepted. Idle gaps
  // go in front of the transaction, so a valid that stays high is driven once.
  task automatic send_action(logic [REGRET_W-1:0] r, logic [SUM_W-1:0] old,
                             logic [PROB_W-1:0] w, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_regret <= r;
    in_old_strategy_sum <= old;
    in_realization_weight <= w;
    in_last_action <= last;
    do @(posedge clk); while (in_stall);
    sb.note_action(r, old, w, last);
    actions_sent++;
  endtask

  // Waits until every expected result has come back, then lets the back end settle.
  task automatic drain_rows();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_discount(logic [PROB_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.discount = 64'(value);
    @(posedge clk);
  endtask

  function automatic logic [REGRET_W-1:0] pick_regret(bit all_negative);
    int mode;
    mode = all_negative ? 0 : $urandom_range(9);
    case (mode)
      0: begin
        return {1'b1, 15'($urandom), $urandom};
      end
      1: begin
        return '0;
      end
      2: begin
        return {1'b0, {47{1'b1}}};
      end
      3, 4: begin
        return REGRET_W'({$urandom, $urandom});
      end
      default: begin
        return REGRET_W'($urandom_range(0, 32'h00ffffff));
      end
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] pick_old_sum();
    case ($urandom_range(3))
      0: begin
        return {SUM_W{1'b1}};
      end
      1: begin
        return {15'($urandom), $urandom};
      end
      default: begin
        return SUM_W'($urandom_range(0, 32'h0fffffff));
      end
    endcase
  endfunction

  // One random row. Most rows are well formed; a few run past the buffer size,
  // carry a stray last flag early, or change weight in mid row.
  task automatic send_random_row();
    int   len;
    int   kind;
    bit   all_negative;
    logic [PROB_W-1:0] w;
    logic last;
    kind = $urandom_range(19);
    len = (kind == 0) ? 16 : (kind == 1) ? $urandom_range(17, 24) : $urandom_range(1, 8);
    all_negative = ($urandom_range(6) == 0);
    w = ($urandom_range(3) == 0) ? PROB_W'($urandom_range(0, 131071))
                                 : PROB_W'($urandom_range(0, 65536));
    for (int k = 0; k < len; k++) begin
      last = (k == len - 1) || (kind == 2 && $urandom_range(4) == 0);
      if (kind == 3 && $urandom_range(1) == 1) w = PROB_W'($urandom);
      send_action(pick_regret(all_negative), pick_old_sum(), w, last);
    end
  endtask

  task automatic run_phase(int sender_pct, int receiver_pct, int quota);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    while (actions_sent < quota) send_random_row();
    drain_rows();
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_regret = '0;
    in_old_strategy_sum = '0;
    in_realization_weight = '0;
    in_last_action = 1'b0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 0;
    actions_sent = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset discount of one.
    write_discount(PROB_W'(65536));
    // Single action with the largest regret and old sum: the sum saturates.
    send_action({1'b0, {47{1'b1}}}, {SUM_W{1'b1}}, PROB_W'(65536), 1'b1);
    // All regrets non-positive: the total is zero and the strategy is uniform.
    send_action({1'b1, 47'd0}, '0, PROB_W'(1000), 1'b0);
    send_action('0, SUM_W'(5), PROB_W'(1000), 1'b0);
    send_action({REGRET_W{1'b1}}, 47'd123456, PROB_W'(1000), 1'b1);
    // Weight above one is clamped; a changing weight keeps the first one.
    send_action(48'd65536, 47'd65536, PROB_W'(131071), 1'b0);
    send_action(48'd3, 47'd0, PROB_W'(7), 1'b0);
    send_action(48'd1, {SUM_W{1'b1}}, PROB_W'(0), 1'b1);
    // A row with no last flag ends by itself when the buffer fills.
    for (int k = 0; k < 17; k++)
      send_action(48'(k * 4096), 47'(k), PROB_W'(32768), (k == 16));
    drain_rows();

    // No discount at all, with a receiver that idles more often than the sender.
    write_discount('0);
    run_phase(28, 71, 150);
    // A discount register above one is clamped to one.
    write_discount(PROB_W'(131071));
    run_phase(71, 28, 290);
    // Back-to-back traffic, opened by a long receiver hold-off.
    write_discount(PROB_W'($urandom_range(1, 65535)));
    hold_cycles = 1500;
    run_phase(0, 0, 430);

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
